>>> src/lap_sw_pkg.sv
// Shared types and constants for the lap stopwatch.
// Holds the stream word layouts, the menu entry codes and the lap ring sizes.
// Depends on nothing.
package lap_sw_pkg;

  // Lap ring and view geometry
  localparam int LAP_SLOTS    = 30;
  localparam int VIEW_ROWS    = 6;
  localparam int SLOT_W       = 5;
  localparam int SCROLL_MAX   = LAP_SLOTS - VIEW_ROWS;
  localparam int WARN_W       = 16;
  localparam logic [WARN_W-1:0] WARN_RESET = 16'd5000;

  // Stream word widths, padded to whole bytes
  localparam int IN_BITS   = 41;
  localparam int IN_W      = 48;
  localparam int OUT_BITS  = 114;
  localparam int OUT_W     = 120;

  // Menu entries in display order
  typedef enum logic [2:0] {
    MENU_RESUME     = 3'd0,
    MENU_EXIT       = 3'd1,
    MENU_CLEAR_TIME = 3'd2,
    MENU_CLEAR_LAPS = 3'd3,
    MENU_CLEAR_BOTH = 3'd4
  } menu_entry_t;

  // Input word, last field in the lowest bits
  typedef struct packed {
    logic [IN_W-IN_BITS-1:0] pad;
    logic [SLOT_W-1:0]       read_slot;
    logic                    press_down;
    logic                    press_up;
    logic                    press_left;
    logic                    press_right;
    logic [31:0]             now_ms;
  } in_item_t;

  // Result word, last field in the lowest bits
  typedef struct packed {
    logic [OUT_W-OUT_BITS-1:0] pad;
    logic [31:0]               read_value;
    logic                      exit_requested;
    logic [31:0]               saved_time_ms;
    logic [SLOT_W-1:0]         saved_slot;
    logic                      lap_saved;
    logic [SLOT_W-1:0]         scroll_position;
    logic                      warning_active;
    logic [31:0]               elapsed_ms;
    logic                      is_running;
    menu_entry_t               menu_position;
    logic                      in_menu;
  } out_item_t;

endpackage

>>> src/lap_stopwatch_top.sv
// Lap stopwatch: one poll word in, one status word out.
// Takes its types and constants from lap_sw_pkg; the lap ring lives in this module.
//
// Each input word is one poll and gives exactly one result word. A poll is
// held in an input register, worked through a single pass of add/compare
// logic against the stopwatch state, and the result lands in the output
// register, which loads only while it is free or being drained. The state
// update loop (run state, offsets, lap ring pointer, menu cursor) allows
// one word per clock while the receiver keeps taking results. The 30-entry
// lap ring uses a valid bit per entry, so reset and the menu's lap clear take
// effect at once with no clearing pass. The warning duration register must
// only be written while no poll is in flight.
module lap_stopwatch_top (
  input  logic                      clk,
  input  logic                      rst,
  // Configuration: warning duration in milliseconds
  input  logic                      cfg_we,
  input  logic [15:0]               cfg_wdata,
  // Poll words
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // now_ms[31:0], press_right, press_left, press_up, press_down,
  // read_slot[4:0], zero fill
  input  logic [lap_sw_pkg::IN_W-1:0]  s_tdata,
  // Result words
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // in_menu, menu_position[2:0], is_running, elapsed_ms[31:0],
  // warning_active, scroll_position[4:0], lap_saved, saved_slot[4:0],
  // saved_time_ms[31:0], exit_requested, read_value[31:0], zero fill
  output logic [lap_sw_pkg::OUT_W-1:0] m_tdata
);
  import lap_sw_pkg::*;

  // Handshake and stage registers
  logic          in_valid;
  in_item_t      in_item;
  logic          out_valid;
  out_item_t     out_item;
  logic          advance;
  logic          fire;

  // Stopwatch state
  logic [WARN_W-1:0] warn_dur;
  logic              menu_mode, menu_mode_next;
  menu_entry_t       menu_cursor, menu_cursor_next;
  logic              run_flag, run_flag_next;
  logic [31:0]       start_time, start_time_next;
  logic [31:0]       acc_offset, acc_offset_next;
  logic [31:0]       shown_time, shown_time_next;
  logic              warn_flag, warn_flag_next;
  logic [31:0]       warn_start, warn_start_next;
  logic [SLOT_W-1:0] next_slot, next_slot_next;
  logic [SLOT_W-1:0] view_top, view_top_next;

  // Lap ring
  logic [31:0]          lap_store [LAP_SLOTS];
  logic [LAP_SLOTS-1:0] lap_valid;

  // Per-poll working signals
  logic [31:0]       lap_time;
  logic [31:0]       warn_age;
  logic [SLOT_W-1:0] slot_inc;
  logic              lap_we;
  logic              lap_clr;
  logic              saved;
  logic              exit_req;
  logic [31:0]       rd_value;
  out_item_t         result;

  // Move words when the output register is free or being drained
  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;
  assign fire     = in_valid && advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_item;

  // Hold the poll word
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_item <= in_item_t'(s_tdata);
    end
  end

  // Hold the result word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
    if (fire) begin
      out_item <= result;
    end
  end

  // Warning duration register
  always_ff @(posedge clk) begin
    if (rst) begin
      warn_dur <= WARN_RESET;
    end else if (cfg_we) begin
      warn_dur <= cfg_wdata;
    end
  end

  // Work out the next state for one poll
  always_comb begin
    menu_mode_next   = menu_mode;
    menu_cursor_next = menu_cursor;
    run_flag_next    = run_flag;
    start_time_next  = start_time;
    acc_offset_next  = acc_offset;
    shown_time_next  = shown_time;
    warn_flag_next   = warn_flag;
    warn_start_next  = warn_start;
    next_slot_next   = next_slot;
    view_top_next    = view_top;
    lap_we           = 1'b0;
    lap_clr          = 1'b0;
    saved            = 1'b0;
    exit_req         = 1'b0;
    lap_time         = in_item.now_ms + acc_offset - start_time;
    warn_age         = in_item.now_ms - warn_start;
    slot_inc         = next_slot + 1'b1;

    if (!menu_mode) begin
      // Timing view: refresh the shown time, then age the warning
      if (run_flag) begin
        shown_time_next = lap_time;
      end
      if (warn_flag && (warn_age > {{(32-WARN_W){1'b0}}, warn_dur})) begin
        warn_flag_next = 1'b0;
      end
      if (!run_flag) begin
        if (in_item.press_right) begin
          run_flag_next   = 1'b1;
          start_time_next = in_item.now_ms;
        end else if (in_item.press_left) begin
          menu_cursor_next = MENU_RESUME;
          menu_mode_next   = 1'b1;
        end
      end else begin
        if (in_item.press_right) begin
          // Save a lap and step the ring pointer
          lap_we        = 1'b1;
          saved         = 1'b1;
          view_top_next = (slot_inc >= SLOT_W'(VIEW_ROWS)) ?
                          slot_inc - SLOT_W'(VIEW_ROWS) : '0;
          if (slot_inc >= SLOT_W'(LAP_SLOTS)) begin
            next_slot_next  = '0;
            warn_flag_next  = 1'b1;
            warn_start_next = in_item.now_ms;
          end else begin
            next_slot_next = slot_inc;
          end
        end else if (in_item.press_left) begin
          run_flag_next   = 1'b0;
          acc_offset_next = acc_offset + (in_item.now_ms - start_time);
        end
      end
      // Scroll the lap view, down first
      if (in_item.press_down && (view_top_next < SLOT_W'(SCROLL_MAX))) begin
        view_top_next = view_top_next + 1'b1;
      end
      if (in_item.press_up && (view_top_next != '0)) begin
        view_top_next = view_top_next - 1'b1;
      end
    end else begin
      // Menu view: move the cursor with wrap-around, then select
      if (in_item.press_down) begin
        menu_cursor_next = (menu_cursor == MENU_CLEAR_BOTH) ? MENU_RESUME :
                           menu_entry_t'(menu_cursor + 3'd1);
      end else if (in_item.press_up) begin
        menu_cursor_next = (menu_cursor == MENU_RESUME) ? MENU_CLEAR_BOTH :
                           menu_entry_t'(menu_cursor - 3'd1);
      end
      if (in_item.press_right) begin
        case (menu_cursor_next)
          MENU_RESUME: begin
            menu_mode_next = 1'b0;
          end
          MENU_EXIT: begin
            exit_req = 1'b1;
          end
          MENU_CLEAR_TIME: begin
            start_time_next = '0;
            acc_offset_next = '0;
            shown_time_next = '0;
            menu_mode_next  = 1'b0;
          end
          MENU_CLEAR_LAPS: begin
            lap_clr        = 1'b1;
            next_slot_next = '0;
            menu_mode_next = 1'b0;
          end
          MENU_CLEAR_BOTH: begin
            start_time_next = '0;
            acc_offset_next = '0;
            shown_time_next = '0;
            lap_clr         = 1'b1;
            next_slot_next  = '0;
            menu_mode_next  = 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Read back a slot as it stands after this poll
  always_comb begin
    rd_value = '0;
    if (in_item.read_slot < SLOT_W'(LAP_SLOTS)) begin
      if (lap_we && (in_item.read_slot == next_slot)) begin
        rd_value = lap_time;
      end else if (!lap_clr && lap_valid[in_item.read_slot]) begin
        rd_value = lap_store[in_item.read_slot];
      end
    end
  end

  // Assemble the result word
  always_comb begin
    result                 = '0;
    result.in_menu         = menu_mode_next;
    result.menu_position   = menu_cursor_next;
    result.is_running      = run_flag_next;
    result.elapsed_ms      = shown_time_next;
    result.warning_active  = warn_flag_next;
    result.scroll_position = view_top_next;
    result.lap_saved       = saved;
    result.saved_slot      = saved ? next_slot : '0;
    result.saved_time_ms   = saved ? lap_time : '0;
    result.exit_requested  = exit_req;
    result.read_value      = rd_value;
  end

  // Advance the stopwatch state once per poll
  always_ff @(posedge clk) begin
    if (rst) begin
      menu_mode   <= 1'b0;
      menu_cursor <= MENU_RESUME;
      run_flag    <= 1'b0;
      start_time  <= '0;
      acc_offset  <= '0;
      shown_time  <= '0;
      warn_flag   <= 1'b0;
      warn_start  <= '0;
      next_slot   <= '0;
      view_top    <= '0;
    end else if (fire) begin
      menu_mode   <= menu_mode_next;
      menu_cursor <= menu_cursor_next;
      run_flag    <= run_flag_next;
      start_time  <= start_time_next;
      acc_offset  <= acc_offset_next;
      shown_time  <= shown_time_next;
      warn_flag   <= warn_flag_next;
      warn_start  <= warn_start_next;
      next_slot   <= next_slot_next;
      view_top    <= view_top_next;
    end
  end

  // Lap ring valid bits: drop all on a lap clear
  always_ff @(posedge clk) begin
    if (rst) begin
      lap_valid <= '0;
    end else if (fire) begin
      if (lap_clr) begin
        lap_valid <= '0;
      end else if (lap_we) begin
        lap_valid[next_slot] <= 1'b1;
      end
    end
  end

  // Lap ring data
  always_ff @(posedge clk) begin
    if (fire && lap_we) begin
      lap_store[next_slot] <= lap_time;
    end
  end

`ifndef SYNTH
  // Ring pointer never leaves the ring
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    next_slot < SLOT_W'(LAP_SLOTS))
    else $error("lap ring pointer out of range");

  // View never scrolls past the last full page
  a_view_range: assert property (@(posedge clk) disable iff (rst)
    view_top <= SLOT_W'(SCROLL_MAX))
    else $error("lap view scrolled past the end");

  // A saved lap only comes from a running watch in timing view
  a_save_ctx: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.lap_saved) |-> (out_item.is_running && !out_item.in_menu))
    else $error("lap saved outside running timing view");

  // An exit request only comes from the menu
  a_exit_ctx: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.exit_requested) |->
      (out_item.in_menu && (out_item.menu_position == MENU_EXIT)))
    else $error("exit requested outside the menu");
`endif

endmodule

>>> test/testbench.sv
// Self-checking bench for the lap stopwatch: drives poll words, predicts each status word.
// Depends on lap_sw_pkg and lap_stopwatch_top; needs nothing else to run.
// Directed script first, then randomised phases under several warning lengths.
module testbench;
  import lap_sw_pkg::*;

  localparam int HOLD_CYCLES = 300;   // long receiver back-pressure stretch
  localparam int SETTLE      = 6;     // cycles to let the pipeline empty
  localparam int WATCHDOG    = 2000;  // cycles with no word moved before giving up

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [15:0]       cfg_wdata = '0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;

  lap_stopwatch_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always #5 clk = ~clk;

  // Scripted polls: expected word typed in only where it is obvious
  typedef struct {
    in_item_t  poll;
    bit        known;
    out_item_t want;
  } poll_row_t;

  poll_row_t  script[$];
  out_item_t  due_status[$];

  // Stopwatch mirror
  logic [15:0] warn_len_q;
  bit          menu_q;
  logic [2:0]  cursor_q;
  bit          run_q;
  logic [31:0] start_q;
  logic [31:0] offset_q;
  logic [31:0] shown_q;
  bit          warn_q;
  logic [31:0] warn_t0_q;
  logic [4:0]  next_q;
  logic [4:0]  top_q;
  logic [31:0] laps_q [LAP_SLOTS];

  // Run bookkeeping
  int  faults;
  int  polls_sent;
  int  results_seen;
  int  laps_seen;
  int  wraps_seen;
  int  picks_seen;
  int  quiet_cycles;
  bit  tx_idle;
  bit  rx_idle;
  bit  hold_req;
  logic [31:0] clock_ms;

  function automatic in_item_t mk_poll(logic [31:0] now, bit right, bit left, bit up,
                                       bit down, logic [4:0] slot);
    in_item_t w;
    w = '0;
    w.now_ms      = now;
    w.press_right = right;
    w.press_left  = left;
    w.press_up    = up;
    w.press_down  = down;
    w.read_slot   = slot;
    return w;
  endfunction

  function automatic out_item_t mk_status(bit in_menu, menu_entry_t pos, bit running,
                                          logic [31:0] elapsed, bit warn, logic [4:0] top,
                                          bit saved, logic [4:0] slot, logic [31:0] lap,
                                          bit quit, logic [31:0] rd);
    out_item_t r;
    r = '0;
    r.in_menu         = in_menu;
    r.menu_position   = pos;
    r.is_running      = running;
    r.elapsed_ms      = elapsed;
    r.warning_active  = warn;
    r.scroll_position = top;
    r.lap_saved       = saved;
    r.saved_slot      = slot;
    r.saved_time_ms   = lap;
    r.exit_requested  = quit;
    r.read_value      = rd;
    return r;
  endfunction

  function void plan_check(in_item_t w);
    poll_row_t row;
    row.poll  = w;
    row.known = 1'b0;
    row.want  = '0;
    script.push_back(row);
  endfunction

  function void plan_known(in_item_t w, out_item_t want);
    poll_row_t row;
    row.poll  = w;
    row.known = 1'b1;
    row.want  = want;
    script.push_back(row);
  endfunction

  // Clear the mirror to its power-up state
  function void reset_watch();
    warn_len_q = WARN_RESET;
    menu_q     = 1'b0;
    cursor_q   = MENU_RESUME;
    run_q      = 1'b0;
    start_q    = '0;
    offset_q   = '0;
    shown_q    = '0;
    warn_q     = 1'b0;
    warn_t0_q  = '0;
    next_q     = '0;
    top_q      = '0;
    foreach (laps_q[i]) laps_q[i] = '0;
  endfunction

  // Advance the mirror by one poll and return the status word it produces
  function automatic out_item_t advance_watch(in_item_t w);
    out_item_t   r;
    logic [31:0] lap;
    r = '0;
    if (!menu_q) begin
      if (run_q) shown_q = w.now_ms + offset_q - start_q;
      if (warn_q && (w.now_ms - warn_t0_q) > {16'd0, warn_len_q}) warn_q = 1'b0;
      if (!run_q) begin
        if (w.press_right) begin
          run_q   = 1'b1;
          start_q = w.now_ms;
        end else if (w.press_left) begin
          cursor_q = MENU_RESUME;
          menu_q   = 1'b1;
        end
      end else if (w.press_right) begin
        // store the lap and move the ring pointer on
        lap             = w.now_ms + offset_q - start_q;
        laps_q[next_q]  = lap;
        r.lap_saved     = 1'b1;
        r.saved_slot    = next_q;
        r.saved_time_ms = lap;
        laps_seen++;
        next_q = next_q + 5'd1;
        top_q  = (next_q >= VIEW_ROWS) ? next_q - 5'(VIEW_ROWS) : 5'd0;
        if (next_q >= LAP_SLOTS) begin
          next_q    = '0;
          warn_q    = 1'b1;
          warn_t0_q = w.now_ms;
          wraps_seen++;
        end
      end else if (w.press_left) begin
        run_q    = 1'b0;
        offset_q = offset_q + (w.now_ms - start_q);
      end
      if (w.press_down && top_q < SCROLL_MAX) top_q = top_q + 5'd1;
      if (w.press_up && top_q > 0) top_q = top_q - 5'd1;
    end else begin
      // menu: down wins over up, cursor wraps over the five entries
      if (w.press_down)
        cursor_q = (cursor_q < MENU_CLEAR_BOTH) ? cursor_q + 3'd1 : MENU_RESUME;
      else if (w.press_up)
        cursor_q = (cursor_q > MENU_RESUME) ? cursor_q - 3'd1 : MENU_CLEAR_BOTH;
      if (w.press_right) begin
        picks_seen++;
        case (menu_entry_t'(cursor_q))
          MENU_RESUME: begin
            menu_q = 1'b0;
          end
          MENU_EXIT: begin
            r.exit_requested = 1'b1;
          end
          MENU_CLEAR_TIME, MENU_CLEAR_LAPS, MENU_CLEAR_BOTH: begin
            if (cursor_q != MENU_CLEAR_LAPS) begin
              start_q  = '0;
              offset_q = '0;
              shown_q  = '0;
            end
            if (cursor_q != MENU_CLEAR_TIME) begin
              foreach (laps_q[i]) laps_q[i] = '0;
              next_q = '0;
            end
            menu_q = 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
    r.in_menu         = menu_q;
    r.menu_position   = menu_entry_t'(cursor_q);
    r.is_running      = run_q;
    r.elapsed_ms      = shown_q;
    r.warning_active  = warn_q;
    r.scroll_position = top_q;
    r.read_value      = (w.read_slot < LAP_SLOTS) ? laps_q[w.read_slot] : 32'd0;
    return r;
  endfunction

  function automatic string differing_fields(out_item_t a, out_item_t b);
    string s;
    s = "";
    if (a.in_menu !== b.in_menu)                 s = {s, " in_menu"};
    if (a.menu_position !== b.menu_position)     s = {s, " menu_position"};
    if (a.is_running !== b.is_running)           s = {s, " is_running"};
    if (a.elapsed_ms !== b.elapsed_ms)           s = {s, " elapsed_ms"};
    if (a.warning_active !== b.warning_active)   s = {s, " warning_active"};
    if (a.scroll_position !== b.scroll_position) s = {s, " scroll_position"};
    if (a.lap_saved !== b.lap_saved)             s = {s, " lap_saved"};
    if (a.saved_slot !== b.saved_slot)           s = {s, " saved_slot"};
    if (a.saved_time_ms !== b.saved_time_ms)     s = {s, " saved_time_ms"};
    if (a.exit_requested !== b.exit_requested)   s = {s, " exit_requested"};
    if (a.read_value !== b.read_value)           s = {s, " read_value"};
    return s;
  endfunction

  function void note_fault(string msg);
    faults++;
    if (faults <= 10) $display("MISMATCH: %s", msg);
  endfunction

  // Offer one poll word, wait for it to be taken, record its expected status
  task automatic send_poll(in_item_t w, bit known, out_item_t want);
    int        gap;
    out_item_t guess;
    gap = tx_idle ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  = w;
    s_tvalid = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    guess = advance_watch(w);
    due_status.push_back(known ? want : guess);
    polls_sent++;
    @(negedge clk);
  endtask

  // Stop offering and hold until every pending status word has come back
  task automatic drain();
    s_tvalid = 1'b0;
    while (due_status.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_warn_len(logic [15:0] value);
    cfg_wdata = value;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we     = 1'b0;
    warn_len_q = value;
  endtask

  task automatic random_phase(int polls, int right_pct, int left_pct, int key_pct,
                              bit pause_mid);
    in_item_t w;
    int       roll;
    for (int i = 0; i < polls; i++) begin
      // mostly small steps of the millisecond count, now and then a long jump
      roll = $urandom_range(0, 99);
      if (roll < 80)      clock_ms = clock_ms + $urandom_range(0, 40);
      else if (roll < 95) clock_ms = clock_ms + $urandom_range(0, 9000);
      else if (roll < 99) clock_ms = clock_ms + $urandom_range(0, 80000);
      else                clock_ms = $urandom;
      w = mk_poll(clock_ms,
                  $urandom_range(0, 99) < right_pct,
                  $urandom_range(0, 99) < left_pct,
                  $urandom_range(0, 99) < key_pct,
                  $urandom_range(0, 99) < key_pct,
                  5'($urandom_range(0, 31)));
      if (pause_mid && i == polls / 2) drain();
      send_poll(w, 1'b0, '0);
    end
  endtask

  // Compare each status word against the oldest expectation
  always @(posedge clk) begin : status_check
    out_item_t got;
    out_item_t want;
    string     bad;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (due_status.size() == 0) begin
        note_fault($sformatf("status word %h arrived with nothing pending", m_tdata));
      end else begin
        want = due_status.pop_front();
        bad  = differing_fields(want, got);
        if (bad != "")
          note_fault($sformatf("word %0d:%s; expected %h got %h",
                               results_seen, bad, want, got));
      end
      results_seen++;
    end
  end

  // Give up if no word moves on either side for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG) begin
        $display("watchdog: no word moved for %0d cycles", quiet_cycles);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Receiver: random stalls per word while rx_idle is set, plus one long hold on request
  initial begin : rx_side
    int gap;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      gap = rx_idle ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
        m_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready = 1'b1;
      @(posedge clk);
      while (!(m_tvalid && m_tready)) @(posedge clk);
    end
  end

  initial begin : stimulus
    faults       = 0;
    polls_sent   = 0;
    results_seen = 0;
    laps_seen    = 0;
    wraps_seen   = 0;
    picks_seen   = 0;
    quiet_cycles = 0;
    hold_req     = 1'b0;
    tx_idle      = 1'b1;
    rx_idle      = 1'b1;
    reset_watch();

    // Directed script, run under the reset warning length
    plan_known(mk_poll(32'd0, 0, 0, 0, 0, 5'd0),
               mk_status(0, MENU_RESUME, 0, 32'd0, 0, 5'd0, 0, 5'd0, 32'd0, 0, 32'd0));
    // start at 100, first lap at 350
    plan_known(mk_poll(32'd100, 1, 0, 0, 0, 5'd0),
               mk_status(0, MENU_RESUME, 1, 32'd0, 0, 5'd0, 0, 5'd0, 32'd0, 0, 32'd0));
    plan_known(mk_poll(32'd350, 1, 0, 0, 0, 5'd0),
               mk_status(0, MENU_RESUME, 1, 32'd250, 0, 5'd0, 1, 5'd0, 32'd250, 0, 32'd250));
    // stop at the top of the count
    plan_known(mk_poll(32'hFFFF_FFFF, 0, 1, 0, 0, 5'd0),
               mk_status(0, MENU_RESUME, 0, 32'hFFFF_FF9B, 0, 5'd0, 0, 5'd0, 32'd0, 0,
                         32'd250));
    // restart; second lap comes out as all ones, with up and down together
    plan_check(mk_poll(32'd500, 1, 0, 0, 0, 5'd0));
    plan_check(mk_poll(32'd600, 1, 0, 1, 1, 5'd1));
    // stop, read slots past the end of the ring
    plan_check(mk_poll(32'd700, 0, 1, 0, 0, 5'd31));
    plan_check(mk_poll(32'd710, 0, 1, 0, 1, 5'd30));
    // walk the menu cursor round both ends
    plan_check(mk_poll(32'd720, 0, 0, 1, 0, 5'd1));
    plan_check(mk_poll(32'd730, 0, 0, 0, 1, 5'd1));
    plan_check(mk_poll(32'd740, 0, 0, 1, 1, 5'd1));
    plan_known(mk_poll(32'd750, 1, 0, 0, 0, 5'd0),
               mk_status(1, MENU_EXIT, 0, 32'd99, 0, 5'd1, 0, 5'd0, 32'd0, 1, 32'd250));
    plan_check(mk_poll(32'd760, 0, 1, 0, 0, 5'd1));
    plan_known(mk_poll(32'd770, 1, 0, 0, 1, 5'd0),
               mk_status(0, MENU_CLEAR_TIME, 0, 32'd0, 0, 5'd1, 0, 5'd0, 32'd0, 0, 32'd250));
    // clear laps, then clear both, then resume
    plan_check(mk_poll(32'd780, 0, 1, 0, 0, 5'd0));
    plan_check(mk_poll(32'd790, 0, 0, 1, 0, 5'd0));
    plan_check(mk_poll(32'd800, 1, 0, 1, 0, 5'd1));
    plan_check(mk_poll(32'd810, 0, 1, 0, 0, 5'd0));
    plan_check(mk_poll(32'd820, 1, 0, 1, 0, 5'd0));
    plan_check(mk_poll(32'd830, 0, 1, 0, 0, 5'd0));
    plan_check(mk_poll(32'd840, 1, 0, 0, 0, 5'd0));
    // every key at once: start takes priority; then a lap and a stop across the wrap
    plan_check(mk_poll(32'd850, 1, 1, 1, 1, 5'd29));
    plan_check(mk_poll(32'h8000_0000, 1, 1, 1, 0, 5'd29));
    plan_check(mk_poll(32'h0000_0000, 0, 1, 0, 0, 5'd0));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (script[i]) send_poll(script[i].poll, script[i].known, script[i].want);
    clock_ms = 32'd1000;

    // Random phases under differing warning lengths and idle patterns
    random_phase(300, 30, 8, 15, 1'b0);
    drain();
    write_warn_len(16'd0);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    random_phase(300, 50, 3, 10, 1'b0);
    drain();
    write_warn_len(16'hFFFF);
    tx_idle  = 1'b1;
    hold_req = 1'b1;
    random_phase(300, 45, 4, 15, 1'b0);
    drain();
    write_warn_len(16'($urandom_range(0, 65535)));
    tx_idle  = 1'b0;
    rx_idle  = 1'b1;
    clock_ms = $urandom;
    random_phase(300, 40, 6, 20, 1'b1);
    drain();
    write_warn_len(16'd3);
    tx_idle = 1'b1;
    random_phase(280, 45, 5, 15, 1'b0);
    drain();

    $display("covered %0d polls (%0d scripted) under five warning lengths,", polls_sent,
             script.size());
    $display("with %0d laps stored, %0d ring wraps and %0d menu selections",
             laps_seen, wraps_seen, picks_seen);
    if (faults == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatching status words", faults);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
